### hw/rtl/open_addressing_hash_table_macros.svh
// Assertion helpers for the hash table RTL; clock is clk, reset is arst_n.
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/oaht_pkg.sv
package oaht_pkg;

	localparam int SLOT_W  = 8;
	localparam int DEPTH   = 1 << SLOT_W;
	localparam int CNT_W   = SLOT_W + 1;
	localparam int STEP_W  = $clog2(SLOT_W + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_EMPTY = {VAL_W{1'b1}};

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_FIND   = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_RESERVED = 2'd2
	} status_t;

	// request to the remainder unit
	typedef struct packed {
		logic              start;
		logic [SLOT_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} rem_req_t;

	// answer from the remainder unit
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [SLOT_W-1:0] rem;
	} rem_rsp_t;

endpackage

### hw/rtl/oaht_rem_unit.sv
// Bit-serial restoring remainder: one shift, compare and subtract per cycle.
module oaht_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  oaht_pkg::rem_req_t req,
	output oaht_pkg::rem_rsp_t rsp
);
	import oaht_pkg::*;

	logic [CNT_W-1:0]  rem_q;
	logic [SLOT_W-1:0] dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W-1:0] shifted;
	logic             ge;
	logic [CNT_W-1:0] rem_next;

	assign shifted  = {rem_q[SLOT_W-1:0], dvd_q[SLOT_W-1]};
	assign ge       = shifted >= dvs_q;
	assign rem_next = ge ? (shifted - dvs_q) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(SLOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath needs no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[SLOT_W-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[SLOT_W-1:0];

endmodule

### hw/rtl/open_addressing_hash_table.sv
// Open-addressing key/value table with linear probing over 256 slots.
// Input transfer (s_axis): tuser carries the operation (insert, find, remove,
// clear all); tdata carries home slot, key and value. The hash is computed
// upstream. Output transfer (m_axis): exactly one result per input transfer,
// tuser carries the status, tdata the slot and the found value.
// cfg_wr_en/cfg_wr_data set the number of slots the probe wraps over; write
// it only while the block is idle. Reset value is 256.
// Sequence: clear all and reserved-key requests go straight from acceptance
// to the result register. Other operations are accepted, pass through the
// bit-serial remainder unit if the home slot lies at or beyond the slot
// count, probe the slots one by one through the single key memory read port,
// then load the output register. One item is in flight at a time;
// s_axis_tready is high only while the sequencer is idle.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed. A stalled receiver holds the finished result in the output
// register; the block waits with its next result until that one is taken.
module open_addressing_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,    // slots_in_use
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // start_slot[7:0], key[39:8], value[71:40]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // slot[7:0], value_out[39:8]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);
	import oaht_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_PROBE,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [CNT_W-1:0] cfg_q;
	logic [CNT_W-1:0] n_eff;

	// request fields
	func_t             func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;

	// probe control
	logic [SLOT_W-1:0] ptr_q;
	logic [CNT_W-1:0]  issue_cnt_q;
	logic              chk_s1;

	// read stage
	logic [KEY_W-1:0]  key_s1;
	logic [VAL_W-1:0]  val_s1;
	logic [SLOT_W-1:0] addr_s1;
	logic              vld_s1;
	logic              last_s1;

	// result waiting for the output register
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [VAL_W-1:0]  res_val_q;

	// output register
	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [VAL_W-1:0]  out_val_q;

	// table storage
	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	// unpacked input fields
	func_t             in_func;
	logic [SLOT_W-1:0] in_start;
	logic [KEY_W-1:0]  in_key;
	logic [VAL_W-1:0]  in_value;
	logic              in_xfer;

	logic              issuing;
	logic [CNT_W-1:0]  ptr_inc;
	logic [SLOT_W-1:0] ptr_next;
	logic [KEY_W-1:0]  rd_key;
	logic              match;
	logic              hit;
	logic              cmp_en;
	logic              mem_we;
	logic              rm_clr;
	logic              out_free;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	assign in_func  = func_t'(s_axis_tuser);
	assign in_start = s_axis_tdata[7:0];
	assign in_key   = s_axis_tdata[39:8];
	assign in_value = s_axis_tdata[71:40];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// zero acts as one, anything above the table size acts as the table size
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (cfg_q > CNT_W'(DEPTH)) begin
			n_eff = CNT_W'(DEPTH);
		end else begin
			n_eff = cfg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CNT_W'(DEPTH);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// home slot at or beyond the count: reduce it in the remainder unit
	assign rem_req.start    = in_xfer && (in_func != FN_CLEAR) && (in_key != KEY_EMPTY)
	                          && ({1'b0, in_start} >= n_eff);
	assign rem_req.dividend = in_start;
	assign rem_req.divisor  = n_eff;

	oaht_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// probe pointer advance with wrap at the slot count
	assign issuing  = (state_q == S_PROBE) && (issue_cnt_q < n_eff);
	assign ptr_inc  = {1'b0, ptr_q} + CNT_W'(1);
	assign ptr_next = (ptr_inc == n_eff) ? '0 : ptr_inc[SLOT_W-1:0];

	// an invalid slot reads as empty
	assign rd_key = vld_s1 ? key_s1 : KEY_EMPTY;
	assign match  = (rd_key == key_q);
	assign hit    = (func_q == FN_INSERT) ? (match || !vld_s1) : match;
	assign cmp_en = (state_q == S_PROBE) && chk_s1;
	assign mem_we = cmp_en && hit && (func_q == FN_INSERT);
	assign rm_clr = cmp_en && hit && (func_q == FN_REMOVE);

	assign out_free = !out_valid_q || m_axis_tready;

	// sequencer with result and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			chk_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			issue_cnt_q  <= '0;
			ptr_q        <= '0;
			func_q       <= FN_INSERT;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_val_q    <= '0;
			out_status_q <= ST_OK;
			out_slot_q   <= '0;
			out_val_q    <= '0;
		end else begin
			chk_s1 <= issuing;
			// drop the taken result unless a new one loads in this cycle
			if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						func_q      <= in_func;
						issue_cnt_q <= '0;
						ptr_q       <= in_start;
						res_slot_q  <= '0;
						res_val_q   <= '0;
						if (in_func == FN_CLEAR) begin
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end else if (in_key == KEY_EMPTY) begin
							res_status_q <= ST_RESERVED;
							state_q      <= S_DONE;
						end else if (rem_req.start) begin
							state_q <= S_MOD;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_MOD: begin
					if (rem_rsp.done) begin
						ptr_q   <= rem_rsp.rem;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (issuing) begin
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
						ptr_q       <= ptr_next;
					end
					if (cmp_en) begin
						if (hit) begin
							res_status_q <= ST_OK;
							res_slot_q   <= addr_s1;
							res_val_q    <= (func_q == FN_FIND) ? val_s1 : '0;
							state_q      <= S_DONE;
						end else if (last_s1) begin
							res_status_q <= ST_MISS;
							res_slot_q   <= '0;
							res_val_q    <= '0;
							state_q      <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_val_q    <= res_val_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q   <= in_key;
			value_q <= in_value;
		end
	end

	// slot valid bits: reset and clear all empty the whole table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (in_xfer && (in_func == FN_CLEAR)) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[addr_s1] <= 1'b1;
		end else if (rm_clr) begin
			vld_q[addr_s1] <= 1'b0;
		end
	end

	// key and value memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[addr_s1] <= key_q;
		end
		key_s1 <= key_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			val_mem[addr_s1] <= value_q;
		end
		val_s1 <= val_mem[ptr_q];
	end

	// read stage side information
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		vld_s1  <= vld_q[ptr_q];
		last_s1 <= (issue_cnt_q == (n_eff - CNT_W'(1)));
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_val_q, out_slot_q};

`include "open_addressing_hash_table_macros.svh"

	`OAHT_ASSERT_NOW(a_miss_zero, m_axis_tvalid && (m_axis_tuser != ST_OK),
		(m_axis_tdata == '0), "non-ok result carries data")
	`OAHT_ASSERT_NOW(a_issue_bound, state_q == S_PROBE, issue_cnt_q <= n_eff,
		"probe issued beyond slot count")
	`OAHT_ASSERT_NOW(a_ptr_range, state_q == S_PROBE, ({1'b0, ptr_q} < n_eff),
		"probe pointer out of range")
	`OAHT_ASSERT_NEXT(a_clear_all, in_xfer && (in_func == FN_CLEAR), (vld_q == '0),
		"clear all left a valid slot")

endmodule
